// ===== rtl/core/fmsm_pkg.sv =====
// ----------------------------------------------------------------------------
// fmsm_pkg
// Shared types and constants for the first-match signature matcher.
// ----------------------------------------------------------------------------
package fmsm_pkg;

    localparam int NUM_RULES_DEF       = 8;
    localparam int MAX_PATTERN_LEN_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 3;
    localparam int POS_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 6;
    localparam int FIELD_W  = 2;
    localparam int ACTIVE_W = 4;
    localparam int HRULE_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_SET  = 2'd1,
        CMD_BYTE = 2'd2,
        CMD_END  = 2'd3
    } cmd_t;

    localparam logic [FIELD_W-1:0] FIELD_MESSAGE = 2'd2;
    localparam logic [FIELD_W-1:0] FIELD_NONE    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_FEED,
        ST_DRAIN,
        ST_SCAN,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic ld_rd;
        logic ld_wr;
        logic feed;
        logic clr_part;
        logic scan;
        logic out_load;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t in_cmd;
        logic load_ok;
        logic last;
        logic out_busy;
    } ctl_sts_t;

endpackage

// ===== rtl/core/first_match_signature_matcher.sv =====
// ----------------------------------------------------------------------------
// first_match_signature_matcher
// Matches tagged log bytes against a table of substring rules and reports
// the lowest-numbered rule that hit at the end of each record.
// ----------------------------------------------------------------------------
// Sequence: a log byte reads one pattern RAM row per rule, pipelined into
// the shift-and update, plus a drain step; an end-of-record result is
// loaded after the rule scan, once the previous result is not stalled.
// Items are taken one at a time: a pattern load reads then writes its row,
// a rule set completes at accept, and in_stall holds off the next item.
// Reset: rule tables, match state and active_rules clear asynchronously;
// the pattern RAM is not cleared and holds garbage until loaded.
module first_match_signature_matcher import fmsm_pkg::*; #(
    parameter int NUM_RULES       = NUM_RULES_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_wdata,
    // input item channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [SLOT_W-1:0]   rule_slot,
    input  logic [POS_W-1:0]    pattern_pos,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic [PLEN_W-1:0]   pattern_length,
    input  logic [FIELD_W-1:0]  target_field,
    input  logic                regex_flag,
    input  logic [FIELD_W-1:0]  field_tag,
    input  logic                field_end,
    // result item channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [HRULE_W-1:0]  hit_rule
);

    localparam int RIDX_W = NUM_RULES > 1 ? $clog2(NUM_RULES) : 1;

    ctl_cmd_t          cmd;
    ctl_sts_t          sts;
    logic [RIDX_W-1:0] idx;

    // Sequencer: walks the rule index for byte updates and the final scan.
    fmsm_ctrl #(
        .NUM_RULES (NUM_RULES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd),
        .idx      (idx)
    );

    // Datapath: holds rules, per-rule partial matches and the result register.
    fmsm_dp #(
        .NUM_RULES       (NUM_RULES),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .command        (command),
        .rule_slot      (rule_slot),
        .pattern_pos    (pattern_pos),
        .byte_value     (byte_value),
        .pattern_length (pattern_length),
        .target_field   (target_field),
        .regex_flag     (regex_flag),
        .field_tag      (field_tag),
        .field_end      (field_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .hit_rule       (hit_rule),
        .cmd            (cmd),
        .idx            (idx),
        .sts            (sts)
    );

endmodule

// ===== rtl/core/fmsm_ram.sv =====
// ----------------------------------------------------------------------------
// fmsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/fmsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmsm_ctrl
// Sequencer: accepts one item; steps the datapath over rules for bytes/ends.
// ----------------------------------------------------------------------------
module fmsm_ctrl import fmsm_pkg::*; #(
    parameter int NUM_RULES = NUM_RULES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd,
    output logic [(NUM_RULES > 1 ? $clog2(NUM_RULES) : 1)-1:0] idx
);

    localparam int RIDX_W = NUM_RULES > 1 ? $clog2(NUM_RULES) : 1;
    localparam int CNT_W  = $clog2(NUM_RULES + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               accept;
    logic               cnt_last;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign cnt_last = (cnt_reg == CNT_W'(NUM_RULES - 1));
    assign idx      = cnt_reg[RIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    case (sts.in_cmd)
                        CMD_LOAD: state_next = sts.load_ok ? ST_LD_RD : ST_IDLE;
                        CMD_SET:  state_next = ST_IDLE;
                        CMD_BYTE: state_next = ST_FEED;
                        CMD_END:  state_next = ST_SCAN;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_RD: state_next = ST_LD_WR;
            ST_LD_WR: state_next = ST_IDLE;
            ST_FEED:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_IDLE;
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        cmd.accept = accept;
        case (state_reg)
            ST_LD_RD: cmd.ld_rd    = 1'b1;
            ST_LD_WR: cmd.ld_wr    = 1'b1;
            ST_FEED:  cmd.feed     = 1'b1;
            ST_DRAIN: cmd.clr_part = sts.last;
            ST_SCAN:  cmd.scan     = 1'b1;
            ST_DONE:
            begin
                cmd.out_load = !sts.out_busy;
                cmd.clr_part = !sts.out_busy;
            end
            default: cmd.ld_rd = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/fmsm_dp.sv =====
// ----------------------------------------------------------------------------
// fmsm_dp
// Datapath: rule tables, pattern RAM, shift-and update, first-hit scan.
// ----------------------------------------------------------------------------
module fmsm_dp import fmsm_pkg::*; #(
    parameter int NUM_RULES       = NUM_RULES_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [ACTIVE_W-1:0]   cfg_wdata,
    input  logic [CMD_W-1:0]      command,
    input  logic [SLOT_W-1:0]     rule_slot,
    input  logic [POS_W-1:0]      pattern_pos,
    input  logic [BYTE_W-1:0]     byte_value,
    input  logic [PLEN_W-1:0]     pattern_length,
    input  logic [FIELD_W-1:0]    target_field,
    input  logic                  regex_flag,
    input  logic [FIELD_W-1:0]    field_tag,
    input  logic                  field_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [HRULE_W-1:0]    hit_rule,
    input  ctl_cmd_t              cmd,
    input  logic [(NUM_RULES > 1 ? $clog2(NUM_RULES) : 1)-1:0] idx,
    output ctl_sts_t              sts
);

    localparam int RIDX_W = NUM_RULES > 1 ? $clog2(NUM_RULES) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ROW_W  = MAX_PATTERN_LEN * BYTE_W;

    logic [LEN_W-1:0]           len_reg   [NUM_RULES];
    logic [FIELD_W-1:0]         tgt_reg   [NUM_RULES];
    logic                       rgx_reg   [NUM_RULES];
    logic [MAX_PATTERN_LEN-1:0] part_reg  [NUM_RULES];
    logic [NUM_RULES-1:0]       hits_reg;
    logic [ACTIVE_W-1:0]        active_reg;

    logic [SLOT_W-1:0]          slot_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [BYTE_W-1:0]          byte_reg;
    logic [FIELD_W-1:0]         tag_reg;
    logic                       last_reg;

    logic                       proc_vld_reg;
    logic [RIDX_W-1:0]          proc_idx_reg;
    logic                       found_reg;
    logic [RIDX_W-1:0]          found_idx_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       hit_reg;
    logic [HRULE_W-1:0]         hit_rule_reg;

    logic [RIDX_W-1:0]          ram_raddr;
    logic [ROW_W-1:0]           ram_rdata;
    logic [ROW_W-1:0]           ram_wdata;

    logic                       slot_ok;
    logic                       pos_ok;
    logic [LEN_W-1:0]           len_sat;
    logic [LEN_W-1:0]           p_len;
    logic [MAX_PATTERN_LEN-1:0] eq_vec;
    logic [MAX_PATTERN_LEN-1:0] end_vec;
    logic [MAX_PATTERN_LEN-1:0] part_new;
    logic                       p_live;
    logic                       p_hit;
    logic                       s_hit;

    assign slot_ok = (int'(rule_slot) < NUM_RULES);
    assign pos_ok  = (int'(pattern_pos) < MAX_PATTERN_LEN);
    assign len_sat = (int'(pattern_length) > MAX_PATTERN_LEN) ?
                     LEN_W'(MAX_PATTERN_LEN) : LEN_W'(pattern_length);

    assign sts.in_cmd   = cmd_t'(command);
    assign sts.load_ok  = slot_ok && pos_ok;
    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg && out_stall;

    // pattern rows, one per rule
    assign ram_raddr = cmd.ld_rd ? RIDX_W'(slot_reg) : idx;

    always_comb
    begin
        ram_wdata = ram_rdata;
        ram_wdata[int'(pos_reg)*BYTE_W +: BYTE_W] = byte_reg;
    end

    fmsm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_RULES)
    ) u_pat_ram (
        .clk   (clk),
        .we    (cmd.ld_wr),
        .waddr (RIDX_W'(slot_reg)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shift-and step for the rule whose row just arrived
    always_comb
    begin
        p_len = len_reg[proc_idx_reg];
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
        begin
            eq_vec[i]  = (ram_rdata[i*BYTE_W +: BYTE_W] == byte_reg) &&
                         (i < int'(p_len));
            end_vec[i] = (i == int'(p_len) - 1);
        end
        p_live   = (tag_reg == tgt_reg[proc_idx_reg]) && (p_len != '0);
        part_new = p_live ? (((part_reg[proc_idx_reg] << 1) |
                              MAX_PATTERN_LEN'(1)) & eq_vec) : '0;
        p_hit    = p_live && (|(part_new & end_vec));
    end

    // first-hit test for the scanned rule
    assign s_hit = (int'(idx) < int'(active_reg)) && !rgx_reg[idx] &&
                   (tgt_reg[idx] != FIELD_NONE) &&
                   ((len_reg[idx] == '0) || hits_reg[idx]);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_RULES; r++)
            begin
                len_reg[r]  <= '0;
                tgt_reg[r]  <= FIELD_NONE;
                rgx_reg[r]  <= 1'b0;
                part_reg[r] <= '0;
            end
            hits_reg      <= '0;
            active_reg    <= '0;
            proc_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            proc_vld_reg  <= cmd.feed;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (cmd.accept && (sts.in_cmd == CMD_SET) && slot_ok)
            begin
                len_reg[RIDX_W'(rule_slot)] <= len_sat;
                tgt_reg[RIDX_W'(rule_slot)] <= target_field;
                rgx_reg[RIDX_W'(rule_slot)] <= regex_flag;
            end
            // drop all partial matches at field end and record end
            if (cmd.clr_part)
            begin
                for (int r = 0; r < NUM_RULES; r++)
                begin
                    part_reg[r] <= '0;
                end
            end
            else if (proc_vld_reg)
            begin
                part_reg[proc_idx_reg] <= part_new;
            end
            if (proc_vld_reg && p_hit)
            begin
                hits_reg[proc_idx_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                hits_reg <= '0;
            end
            if (cmd.accept)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan && s_hit && !found_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg <= rule_slot;
            pos_reg  <= pattern_pos;
            byte_reg <= byte_value;
            tag_reg  <= field_tag;
            last_reg <= field_end;
        end
        proc_idx_reg <= idx;
        if (cmd.scan && s_hit && !found_reg)
        begin
            found_idx_reg <= idx;
        end
        if (cmd.out_load)
        begin
            hit_reg      <= found_reg;
            hit_rule_reg <= found_reg ? HRULE_W'(found_idx_reg) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_rule  = hit_rule_reg;

endmodule
